// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the point-in-polygon RTL.
// Files that assert include this header; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Package for the point-in-polygon test: payload structs, widths and orientation helpers.
// Used by pip_step_eval, point_in_polygon_test and the testbench; depends on nothing else.
package pip_pkg;

  localparam int unsigned VertW        = 7;
  localparam int unsigned CountW       = 11;
  localparam int unsigned RayEndXMax   = 4095;
  localparam int unsigned CoordW       = $clog2(RayEndXMax + 1);
  localparam int unsigned DiffW        = CoordW + 1;
  localparam int unsigned ProdW        = 2 * DiffW;
  localparam int unsigned CountFieldMax = (1 << CountW) - 1;

  localparam int unsigned RAY_END_X_DEF    = 101;
  localparam int unsigned MAX_VERTICES_DEF = 1024;

  // Configuration register indexes.
  localparam logic REG_TEST_X = 1'b0;
  localparam logic REG_TEST_Y = 1'b1;

  typedef logic [VertW-1:0]         vert_t;
  typedef logic [CoordW-1:0]        coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic [CountW-1:0]        count_t;

  typedef struct packed {
    vert_t vertex_x;
    vert_t vertex_y;
    logic  last_vertex;
  } pip_in_t;

  typedef struct packed {
    logic   inside_res;
    count_t crossings;
  } pip_out_t;

  typedef struct packed {
    logic degen;
    logic add;
  } pip_eval_t;

  typedef enum logic [1:0] {
    OR_ZERO,
    OR_POS,
    OR_NEG
  } orient_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    return diff_t'($signed({1'b0, a}) - $signed({1'b0, b}));
  endfunction

  function automatic logic opposite(input diff_t p, input diff_t q);
    return (p != '0) && (q != '0) && (p[DiffW-1] != q[DiffW-1]);
  endfunction

  function automatic logic [DiffW-1:0] mag(input diff_t p);
    return p[DiffW-1] ? $unsigned(-p) : $unsigned(p);
  endfunction

  // Three-way orientation of c against segment a->b. In the collinear case
  // with no opposing components, d2 is a non-negative multiple of d1, so the
  // length comparison reduces to a per-component magnitude comparison.
  function automatic orient_t orient_gen(input coord_t ax, input coord_t ay,
                                         input coord_t bx, input coord_t by,
                                         input coord_t cx, input coord_t cy);
    diff_t d1x, d1y, d2x, d2y;
    prod_t l, r;
    d1x = coord_diff(bx, ax);
    d1y = coord_diff(by, ay);
    d2x = coord_diff(cx, ax);
    d2y = coord_diff(cy, ay);
    l   = d1x * d2y;
    r   = d1y * d2x;
    if (l < r) return OR_POS;
    if (l > r) return OR_NEG;
    if (opposite(d1x, d2x) || opposite(d1y, d2y)) return OR_NEG;
    if ((mag(d2x) <= mag(d1x)) && (mag(d2y) <= mag(d1y))) return OR_ZERO;
    return OR_POS;
  endfunction

  // Orientation of c against the horizontal ray z->(ex, zy); the cross
  // product collapses to a sign test since the ray has no y extent.
  function automatic orient_t orient_ray(input coord_t zx, input coord_t zy,
                                         input coord_t ex,
                                         input coord_t cx, input coord_t cy);
    diff_t dr, dx, dy;
    dr = coord_diff(ex, zx);
    dx = coord_diff(cx, zx);
    dy = coord_diff(cy, zy);
    if ((dr == '0) || (dy == '0)) begin
      if (opposite(dr, dx)) return OR_NEG;
      if ((mag(dx) <= mag(dr)) && (dy == '0)) return OR_ZERO;
      return OR_POS;
    end
    if (dr[DiffW-1] != dy[DiffW-1]) return OR_POS;
    return OR_NEG;
  endfunction

  // True when the product of two orientations is zero or negative.
  function automatic logic orient_le0(input orient_t a, input orient_t b);
    return (a == OR_ZERO) || (b == OR_ZERO) || (a != b);
  endfunction

endpackage

// ===== rtl/pip_step_eval.sv =====
// Per-vertex decision logic: degenerate-vertex hit on the ray and crossing detection.
// Depends on pip_pkg for the orientation functions and the result struct.
module pip_step_eval #(
  parameter int unsigned RAY_END_X = pip_pkg::RAY_END_X_DEF
) (
  input  pip_pkg::vert_t     vertex_x,
  input  pip_pkg::vert_t     vertex_y,
  input  pip_pkg::vert_t     prev_x,
  input  pip_pkg::vert_t     prev_y,
  input  pip_pkg::vert_t     test_x,
  input  pip_pkg::vert_t     test_y,
  input  logic               on_ray,
  output pip_pkg::pip_eval_t eval
);
  import pip_pkg::*;

  localparam coord_t RayEnd = CoordW'(RAY_END_X);

  coord_t  vx, vy, px, py, zx, zy;
  orient_t o_vz, o_ve, r_v, r_p;
  logic    cross_plain, cross_onray;

  assign vx = CoordW'(vertex_x);
  assign vy = CoordW'(vertex_y);
  assign px = CoordW'(prev_x);
  assign py = CoordW'(prev_y);
  assign zx = CoordW'(test_x);
  assign zy = CoordW'(test_y);

  // A zero-length vertex segment meets the ray only at one of its ends.
  assign eval.degen = ((vx == zx) && (vy == zy)) || ((vx == RayEnd) && (vy == zy));

  assign o_vz = orient_gen(vx, vy, px, py, zx, zy);
  assign o_ve = orient_gen(vx, vy, px, py, RayEnd, zy);
  assign r_v  = orient_ray(zx, zy, RayEnd, vx, vy);
  assign r_p  = orient_ray(zx, zy, RayEnd, px, py);

  assign cross_plain = orient_le0(o_vz, o_ve) && orient_le0(r_v, r_p);
  assign cross_onray = (r_v != OR_ZERO) && (r_p != OR_ZERO) && (r_v != r_p);

  assign eval.add = !eval.degen && (on_ray ? cross_onray : cross_plain);

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// Top level of the ray-crossing point-in-polygon test.
// Depends on pip_pkg, pip_step_eval and assert_macros.svh.

// Vertices stream in at one per cycle unless a closing vertex is held; each
// accepted vertex sits in the input register while the orientation logic in
// pip_step_eval updates the polygon state, and the closing vertex loads the
// result register, which then holds the result until it is taken. Sustained
// rate is one vertex per clock, limited by the combinational orientation
// products; the closing vertex waits in the input register only while an
// earlier result has not yet been taken. The user must write the test point
// through the configuration port between polygons; the block does not enforce it.
module point_in_polygon_test #(
  parameter int unsigned RAY_END_X    = pip_pkg::RAY_END_X_DEF,
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pip_pkg::pip_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pip_pkg::pip_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  pip_pkg::vert_t    cfg_data
);
  import pip_pkg::*;

  `include "assert_macros.svh"

  localparam count_t CountCap = (MAX_VERTICES < CountFieldMax) ?
                                CountW'(MAX_VERTICES) : CountW'(CountFieldMax);

  vert_t     test_x, test_y;
  pip_in_t   in_q;
  logic      in_q_valid;
  vert_t     prev_x, prev_y, prev_x_next, prev_y_next;
  logic      on_ray, on_ray_next;
  logic      expect_first, expect_first_next;
  count_t    crossing_count, crossing_count_next, count_upd;
  pip_eval_t eval;
  logic      advance;

  pip_step_eval #(
    .RAY_END_X(RAY_END_X)
  ) u_eval (
    .vertex_x(in_q.vertex_x),
    .vertex_y(in_q.vertex_y),
    .prev_x  (prev_x),
    .prev_y  (prev_y),
    .test_x  (test_x),
    .test_y  (test_y),
    .on_ray  (on_ray),
    .eval    (eval)
  );

  // The closing vertex can only leave once the result register is free.
  assign advance  = in_q_valid && (!in_q.last_vertex || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_comb begin
    prev_x_next       = prev_x;
    prev_y_next       = prev_y;
    on_ray_next       = on_ray;
    expect_first_next = expect_first;
    count_upd         = crossing_count;
    if (expect_first) begin
      prev_x_next       = in_q.vertex_x;
      prev_y_next       = in_q.vertex_y;
      expect_first_next = 1'b0;
    end else if (eval.degen) begin
      on_ray_next = 1'b1;
    end else begin
      on_ray_next = 1'b0;
      prev_x_next = in_q.vertex_x;
      prev_y_next = in_q.vertex_y;
      if (eval.add && (crossing_count < CountCap)) begin
        count_upd = crossing_count + 1'b1;
      end
    end
    crossing_count_next = count_upd;
    if (in_q.last_vertex) begin
      prev_x_next         = '0;
      prev_y_next         = '0;
      on_ray_next         = 1'b0;
      expect_first_next   = 1'b1;
      crossing_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_x <= '0;
      test_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEST_X: test_x <= cfg_data;
        REG_TEST_Y: test_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x         <= '0;
      prev_y         <= '0;
      on_ray         <= 1'b0;
      expect_first   <= 1'b1;
      crossing_count <= '0;
    end else if (advance) begin
      prev_x         <= prev_x_next;
      prev_y         <= prev_y_next;
      on_ray         <= on_ray_next;
      expect_first   <= expect_first_next;
      crossing_count <= crossing_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q.last_vertex) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_q.last_vertex) begin
      out_data.inside_res <= count_upd[0];
      out_data.crossings  <= count_upd;
    end
  end

  `ASSERT_ALWAYS(a_rst_clears, rst |=> (!out_valid && !in_q_valid && expect_first), "reset did not clear control state")
  `ASSERT_CHK(a_count_cap, crossing_count <= CountCap, "crossing count passed its cap")
  `ASSERT_CHK(a_close_emits, (advance && in_q.last_vertex) |=> (out_valid && expect_first && (crossing_count == '0) && !on_ray), "closing vertex did not emit and clear")
  `ASSERT_CHK(a_onray_not_first, on_ray |-> !expect_first, "on-ray flag set before a first vertex")

endmodule

// ===== verif/point_in_polygon_test_tb.sv =====
// Self-checking testbench for point_in_polygon_test: directed polygons, then random ones and a saturating chain.
// Depends on pip_pkg and the point_in_polygon_test RTL; reads no files.
module point_in_polygon_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam int RAY_END     = 101;
  localparam int VERTEX_CAP  = 1024;
  localparam int COUNT_CAP   = (VERTEX_CAP < 2047) ? VERTEX_CAP : 2047;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 95;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int LONG_CHAIN  = 1030;

  typedef struct packed {
    pip_in_t  item;
    logic     typed;
    pip_out_t want;
  } dir_row_t;

  // Row 0 runs at the reset test point, every later row at (50, 50).
  localparam int NDIR = 21;
  localparam dir_row_t DIRECTED [NDIR] = '{
    '{'{7'd10,  7'd10,  1'b1}, 1'b1, '{1'b0, 11'd0}},  // closing mark on the first vertex
    '{'{7'd0,   7'd0,   1'b0}, 1'b0, '{1'b0, 11'd0}},  // square around the point
    '{'{7'd100, 7'd0,   1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd100, 7'd100, 1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd0,   7'd100, 1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd0,   7'd0,   1'b1}, 1'b1, '{1'b1, 11'd1}},
    '{'{7'd30,  7'd20,  1'b0}, 1'b0, '{1'b0, 11'd0}},  // vertex on the test point
    '{'{7'd50,  7'd50,  1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd60,  7'd90,  1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd30,  7'd90,  1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd30,  7'd20,  1'b1}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd90,  7'd20,  1'b0}, 1'b0, '{1'b0, 11'd0}},  // vertex on the ray end
    '{'{7'd101, 7'd50,  1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd90,  7'd80,  1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd0,   7'd127, 1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd90,  7'd20,  1'b1}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd127, 7'd127, 1'b0}, 1'b0, '{1'b0, 11'd0}},  // coordinate extremes
    '{'{7'd0,   7'd0,   1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd127, 7'd0,   1'b0}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd127, 7'd127, 1'b1}, 1'b0, '{1'b0, 11'd0}},
    '{'{7'd0,   7'd127, 1'b1}, 1'b1, '{1'b0, 11'd0}}
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pip_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pip_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_index = REG_TEST_X;
  vert_t    cfg_data = '0;

  point_in_polygon_test #(
    .RAY_END_X   (RAY_END),
    .MAX_VERTICES(VERTEX_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted polygon state and test point.
  vert_t  point_x = '0;
  vert_t  point_y = '0;
  vert_t  held_x = '0;
  vert_t  held_y = '0;
  bit     ray_touch = 1'b0;
  bit     polygon_open = 1'b0;
  count_t tally = '0;

  pip_out_t pending_verdicts[$];
  int       fail_count = 0;
  int       verdicts_seen = 0;
  int       vertices_sent = 0;
  int       burst_left = 0;
  bit       steady = 1'b0;
  int       cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Three-way turn of c against a->b, with the collinear tie-break by length.
  function automatic int turn_dir(input int ax, ay, bx, by, cx, cy);
    int d1x, d1y, d2x, d2y, l, r;
    d1x = bx - ax;
    d1y = by - ay;
    d2x = cx - ax;
    d2y = cy - ay;
    l = d1x * d2y;
    r = d1y * d2x;
    if (l < r) return 1;
    if (l > r) return -1;
    if (d1x * d2x < 0 || d1y * d2y < 0) return -1;
    if (d1x * d1x + d1y * d1y >= d2x * d2x + d2y * d2y) return 0;
    return 1;
  endfunction

  function automatic bit segments_meet(input int px, py, qx, qy, rx, ry, sx, sy);
    return (turn_dir(px, py, qx, qy, rx, ry) * turn_dir(px, py, qx, qy, sx, sy) <= 0)
        && (turn_dir(rx, ry, sx, sy, px, py) * turn_dir(rx, ry, sx, sy, qx, qy) <= 0);
  endfunction

  task automatic advance_polygon(input pip_in_t v, output bit closes, output pip_out_t res);
    int  vx, vy, zx, zy, hx, hy;
    bit  add;
    vx = int'(v.vertex_x);
    vy = int'(v.vertex_y);
    zx = int'(point_x);
    zy = int'(point_y);
    hx = int'(held_x);
    hy = int'(held_y);
    add = 1'b0;
    if (!polygon_open) begin
      held_x = v.vertex_x;
      held_y = v.vertex_y;
      polygon_open = 1'b1;
    end else if (segments_meet(zx, zy, RAY_END, zy, vx, vy, vx, vy)) begin
      ray_touch = 1'b1;
    end else begin
      if (!ray_touch) begin
        add = segments_meet(vx, vy, hx, hy, zx, zy, RAY_END, zy);
      end else begin
        // After a vertex on the ray, count only a true change of side.
        add = turn_dir(zx, zy, RAY_END, zy, vx, vy)
            * turn_dir(zx, zy, RAY_END, zy, hx, hy) < 0;
        ray_touch = 1'b0;
      end
      held_x = v.vertex_x;
      held_y = v.vertex_y;
    end
    if (add && int'(tally) < COUNT_CAP) tally = tally + 1'b1;
    closes = v.last_vertex;
    res = '0;
    if (closes) begin
      res.inside_res = tally[0];
      res.crossings  = tally;
      held_x = '0;
      held_y = '0;
      ray_touch = 1'b0;
      tally = '0;
      polygon_open = 1'b0;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_verdicts
    pip_out_t want;
    if (!rst && out_valid && out_ready) begin
      verdicts_seen <= verdicts_seen + 1;
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("unexpected result inside=%0d crossings=%0d",
                               out_data.inside_res, out_data.crossings));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.inside_res !== want.inside_res)
          note_failure($sformatf("inside_res: expected %0d, got %0d",
                                 want.inside_res, out_data.inside_res));
        if (out_data.crossings !== want.crossings)
          note_failure($sformatf("crossings: expected %0d, got %0d",
                                 want.crossings, out_data.crossings));
      end
    end
  end

  // Result side: runs of steady, random and sparse ready, plus one long hold-off
  // while the sender keeps going, so the closing vertex backs up at the input.
  initial begin : result_side
    int  mode, run;
    bit  held_off;
    held_off = 1'b0;
    @(negedge rst);
    forever begin
      if (!held_off && verdicts_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      run = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_vertex(input pip_in_t v, input bit typed, input pip_out_t want);
    bit       closes;
    pip_out_t got;
    int       gap;
    if (burst_left == 0) begin
      if (!steady) begin
        gap = $urandom_range(1, 10);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_data <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_polygon(v, closes, got);
    if (closes) pending_verdicts.push_back(typed ? want : got);
    vertices_sent++;
  endtask

  // Waits until the block has delivered everything and finished any vertex
  // that produces no result.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_test_point(input vert_t x, input vert_t y);
    drain_block();
    cfg_we <= 1'b1;
    cfg_index <= REG_TEST_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= REG_TEST_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    point_x = x;
    point_y = y;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // Vertices favor the test point, the ray end and the ray's own row.
  task automatic pick_vertex(output pip_in_t v);
    v.last_vertex = 1'b0;
    case ($urandom_range(0, 9))
      0: begin
        v.vertex_x = point_x;
        v.vertex_y = point_y;
      end
      1: begin
        v.vertex_x = vert_t'(RAY_END);
        v.vertex_y = point_y;
      end
      2: begin
        v.vertex_x = vert_t'($urandom_range(0, 127));
        v.vertex_y = point_y;
      end
      3: begin
        v.vertex_x = point_x;
        v.vertex_y = vert_t'($urandom_range(0, 127));
      end
      4: begin
        v.vertex_x = vert_t'($urandom_range(0, 127));
        v.vertex_y = vert_t'($urandom_range(0, 127));
      end
      default: begin
        v.vertex_x = vert_t'($urandom_range(0, 100));
        v.vertex_y = vert_t'($urandom_range(0, 100));
      end
    endcase
  endtask

  task automatic send_random_polygon();
    pip_in_t start_v, v;
    int      n;
    pick_vertex(start_v);
    if ($urandom_range(0, 9) == 0) begin
      // Broken sequence: closing marks at random, closing vertex unrelated.
      n = $urandom_range(1, 8);
      repeat (n) begin
        pick_vertex(v);
        v.last_vertex = ($urandom_range(0, 3) == 0);
        send_vertex(v, 1'b0, '0);
      end
    end else begin
      n = $urandom_range(2, 10);
      send_vertex(start_v, 1'b0, '0);
      repeat (n - 1) begin
        pick_vertex(v);
        send_vertex(v, 1'b0, '0);
      end
      start_v.last_vertex = 1'b1;
      send_vertex(start_v, 1'b0, '0);
    end
  endtask

  // Zigzag across the ray at (50, 50): every edge crosses, so the count saturates.
  task automatic send_long_chain();
    pip_in_t start_v, v;
    start_v.vertex_x = vert_t'($urandom_range(51, 100));
    start_v.vertex_y = vert_t'($urandom_range(0, 49));
    start_v.last_vertex = 1'b0;
    send_vertex(start_v, 1'b0, '0);
    for (int i = 1; i < LONG_CHAIN; i++) begin
      v.vertex_x = vert_t'($urandom_range(51, 100));
      v.vertex_y = (i % 2) ? vert_t'($urandom_range(51, 100)) : vert_t'($urandom_range(0, 49));
      v.last_vertex = 1'b0;
      send_vertex(v, 1'b0, '0);
    end
    start_v.last_vertex = 1'b1;
    send_vertex(start_v, 1'b0, '0);
  endtask

  initial begin : stimulus
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) begin
      if (i == 1) set_test_point(7'd50, 7'd50);
      send_vertex(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_test_point(7'd0, 7'd0);
        1: set_test_point(7'd100, 7'd100);
        2: set_test_point(7'd127, 7'd127);
        3: set_test_point(vert_t'(RAY_END), 7'd50);
        4: set_test_point(7'd0, 7'd100);
        5: set_test_point(7'd100, 7'd0);
        6: set_test_point(7'd50, 7'd50);
        default: set_test_point(vert_t'($urandom_range(0, 127)),
                                vert_t'($urandom_range(0, 127)));
      endcase
      if (phase == 6) begin
        send_long_chain();
      end else begin
        target = vertices_sent + PHASE_ITEMS;
        while (vertices_sent < target) send_random_polygon();
      end
    end

    drain_block();
    repeat (TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_step_eval.sv
rtl/point_in_polygon_test.sv
verif/point_in_polygon_test_tb.sv
